// ----- rtl/pn_pkg.sv -----
// Shared constants, types and state codes of the peak normalizer.
`timescale 1ns / 1ps

package pn_pkg;

    // Sample width and derived widths
    localparam int SAMPLE_BITS = 16;
    localparam int MAG_W       = SAMPLE_BITS + 1;    // magnitude up to 2^(SAMPLE_BITS-1)
    localparam int QUO_W       = SAMPLE_BITS - 1;    // quotient bits when |sample| < peak
    localparam int CNT_W       = $clog2(QUO_W);

    // Full scale (1.0) as a magnitude
    localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(1) << (SAMPLE_BITS - 1);

    // Saturation limits of the signed result
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Item function codes
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_SCALE   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_DONE = 3'b100
    } pn_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } pn_div_stat_t;

endpackage

// ----- rtl/peak_normalizer_top.sv -----
// Peak normalizer top level: peak tracking, scale sequencer and output register.
// A measure word (func 0) is absorbed and gives no result; it updates the running peak
// magnitude, and the word after one flagged last, or after any scale word, starts a fresh
// peak. A scale word (func 1) gives one result, sample * 1.0 / peak truncated toward zero
// and saturated. A scale word whose magnitude reaches the peak, or a zero peak, resolves
// without division; any other scale word runs the divider for one quotient bit per cycle
// (SAMPLE_BITS-1 bits). The input is not ready while a scale word is in work; the output
// register holds a finished word so the next input word can be taken while the result
// waits downstream.
`timescale 1ns / 1ps

module peak_normalizer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic signed [pn_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                               s_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pn_pkg::SAMPLE_BITS-1:0] m_scaled_sample,
    output logic                               m_last_out,
    output logic                               m_peak_zero
);

    pn_pkg::pn_state_t state_reg, state_next;
    logic [pn_pkg::MAG_W-1:0]       peak_reg, peak_next;
    logic                           restart_reg, restart_next;
    logic [pn_pkg::SAMPLE_BITS-1:0] res_reg, res_next;
    logic                           zero_reg, zero_next;
    logic                           last_reg, last_next;
    logic                           neg_reg, neg_next;
    logic                           m_valid_reg, m_valid_next;
    logic [pn_pkg::SAMPLE_BITS-1:0] m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;
    logic                           m_zero_reg, m_zero_next;

    logic [pn_pkg::MAG_W-1:0]       s_ext;
    logic [pn_pkg::MAG_W-1:0]       s_mag;
    logic                           accept;
    logic                           div_start;
    logic [pn_pkg::QUO_W-1:0]       div_quo;
    pn_pkg::pn_div_stat_t           div_stat;
    logic [pn_pkg::SAMPLE_BITS-1:0] quo_ext;

    // Magnitude of the incoming sample
    always_comb begin
        s_ext = {s_sample[pn_pkg::SAMPLE_BITS-1], s_sample};
        s_mag = s_sample[pn_pkg::SAMPLE_BITS-1] ? (~s_ext + 1'b1) : s_ext;
    end

    assign s_ready = (state_reg == pn_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign quo_ext = {1'b0, div_quo};

    // Sequencer and peak tracking
    always_comb begin
        state_next   = state_reg;
        peak_next    = peak_reg;
        restart_next = restart_reg;
        res_next     = res_reg;
        zero_next    = zero_reg;
        last_next    = last_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_zero_next  = m_zero_reg;
        div_start    = 1'b0;

        // Drop the output word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            pn_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_func == pn_pkg::FUNC_MEASURE) begin
                        if (restart_reg || (s_mag > peak_reg)) begin
                            peak_next = s_mag;
                        end
                        restart_next = s_last;
                    end else begin
                        restart_next = 1'b1;
                        last_next    = s_last;
                        neg_next     = s_sample[pn_pkg::SAMPLE_BITS-1];
                        zero_next    = 1'b0;
                        if (peak_reg == '0) begin
                            res_next   = '0;
                            zero_next  = 1'b1;
                            state_next = pn_pkg::ST_DONE;
                        end else if (s_mag >= peak_reg) begin
                            res_next   = s_sample[pn_pkg::SAMPLE_BITS-1] ?
                                         pn_pkg::SAT_MIN : pn_pkg::SAT_MAX;
                            state_next = pn_pkg::ST_DONE;
                        end else begin
                            div_start  = 1'b1;
                            state_next = pn_pkg::ST_BUSY;
                        end
                    end
                end
            end
            pn_pkg::ST_BUSY: begin
                if (div_stat.done) begin
                    res_next   = neg_reg ? (pn_pkg::SAMPLE_BITS'(0) - quo_ext) : quo_ext;
                    state_next = pn_pkg::ST_DONE;
                end
            end
            pn_pkg::ST_DONE: begin
                // Hand the result over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_last_next  = last_reg;
                    m_zero_next  = zero_reg;
                    state_next   = pn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pn_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pn_pkg::ST_IDLE;
            peak_reg    <= '0;
            restart_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            peak_reg    <= peak_next;
            restart_reg <= restart_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        zero_reg   <= zero_next;
        last_reg   <= last_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_zero_reg <= m_zero_next;
    end

    pn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_mag[pn_pkg::QUO_W-1:0]),
        .divisor  (peak_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign m_valid         = m_valid_reg;
    assign m_scaled_sample = m_data_reg;
    assign m_last_out      = m_last_reg;
    assign m_peak_zero     = m_zero_reg;

    // Divider starts only from an idle sequencer and an idle divider
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (state_reg == pn_pkg::ST_IDLE) && !div_stat.busy)
        else $error("divider started while busy");

    // Divider completion only lands while the sequencer waits for it
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == pn_pkg::ST_BUSY))
        else $error("divider done outside busy state");

    // A zero-peak word always carries a zero sample
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_peak_zero) |-> (m_scaled_sample == '0))
        else $error("peak_zero word with nonzero sample");

    // Peak never exceeds full scale
    a_peak_range: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg <= pn_pkg::FULL_SCALE)
        else $error("peak magnitude out of range");

    // A finished result is never overwritten before it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_scaled_sample))
        else $error("output word lost");

endmodule

// ----- rtl/pn_div.sv -----
// Iterative restoring divider: one quotient bit per cycle by shared compare and subtract.
`timescale 1ns / 1ps

module pn_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [pn_pkg::QUO_W-1:0]          dividend,
    input  logic [pn_pkg::MAG_W-1:0]          divisor,
    output logic [pn_pkg::QUO_W-1:0]          quotient,
    output pn_pkg::pn_div_stat_t              stat
);

    logic [pn_pkg::MAG_W-1:0] rem_reg;
    logic [pn_pkg::MAG_W-1:0] div_reg;
    logic [pn_pkg::QUO_W-1:0] quo_reg;
    logic [pn_pkg::CNT_W-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [pn_pkg::MAG_W-1:0] shifted;
    logic [pn_pkg::MAG_W:0]   trial;
    logic                     qbit;

    // Shift the partial remainder and try the subtract
    always_comb begin
        shifted = {rem_reg[pn_pkg::MAG_W-2:0], 1'b0};
        trial   = {1'b0, shifted} - {1'b0, div_reg};
        qbit    = ~trial[pn_pkg::MAG_W];
    end

    // Control: load on start, count down the quotient bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= pn_pkg::CNT_W'(pn_pkg::QUO_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: keep remainder when the subtract goes negative
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {{(pn_pkg::MAG_W-pn_pkg::QUO_W){1'b0}}, dividend};
            div_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= qbit ? trial[pn_pkg::MAG_W-1:0] : shifted;
            quo_reg <= {quo_reg[pn_pkg::QUO_W-2:0], qbit};
        end
    end

    assign quotient = quo_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule
